// ===== src/tli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and codes for the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    // knot store depth; the interpolator's index and size widths are sized for it
    localparam int TABLE_DEPTH = 256;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_LOW    = 2'd1;
    localparam logic [1:0] REGION_HIGH   = 2'd2;
    localparam logic [1:0] REGION_ZERO   = 2'd3;

    localparam int WEIGHT_W = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] weight;
    } div_rsp_t;

endpackage

// ===== src/table_linear_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a table of Q16.16 knots.
// ----------------------------------------------------------------------------
// Usage: load knots with action 0 requests (knot_index, value_x, value_y);
// each is written on acceptance and gives no result. An action 1 request
// carries a query x and gives one result: interp_y, interval_index, region
// and final_result. table_size is written through cfg_we / cfg_wdata; the
// user must do so only while idle, as the block does not enforce it. One
// request is worked on at a time; in_stall is high from acceptance to
// completion. A clamped query reads the first, second and last knot x and
// the end knot y. An inside query runs a binary search on the memory's
// single port, then the bit-serial weight divider, the split multiply and add.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled result holds until out_stall drops.
// Reset clears the control state and sets table_size to 2; knot memory
// contents are undefined until written.
// ----------------------------------------------------------------------------
module table_linear_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  knot_index,
    input  logic [31:0] value_x,
    input  logic [31:0] value_y,
    input  logic        final_query,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] interp_y,
    output logic [7:0]  interval_index,
    output logic [1:0]  region,
    output logic        final_result
);
    import tli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_X0, ST_X1, ST_XN, ST_YEND, ST_SEARCH, ST_CMP, ST_LO,
        ST_HI, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_ADD, ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [8:0]         table_size_reg;
    logic signed [31:0] q_reg, q_next;
    logic               fin_reg, fin_next;
    logic [8:0]         n_reg, n_next;
    logic               asc_reg, asc_next;
    logic signed [31:0] x0_reg, x0_next;
    logic [8:0]         lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [8:0]         idx_reg, idx_next;
    logic [1:0]         reg_reg, reg_next;
    logic signed [31:0] xlo_reg, xlo_next, ylo_reg, ylo_next, yhi_reg, yhi_next;
    logic [32:0]        diff_reg, diff_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [33:0]        pl_reg, pl_next;
    logic signed [33:0] ph_reg, ph_next;
    logic [47:0]        psum_reg, psum_next;
    logic [31:0]        res_y_reg, res_y_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_y_reg, out_y_next;
    logic [7:0]         out_idx_reg, out_idx_next;
    logic [1:0]         out_reg_reg, out_reg_next;
    logic               out_fin_reg, out_fin_next;

    logic [8:0]         n_eff;
    logic [9:0]         mid_sum;
    logic [8:0]         rd_idx;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [31:0]        rx, ry;
    logic signed [31:0] rx_s, ry_s, xmin, xmax;
    logic signed [32:0] den, num;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign in_stall = (state_reg != ST_IDLE);
    assign mem_we   = in_valid && !in_stall && (action == ACT_WRITE)
                      && (int'(knot_index) < TABLE_DEPTH);
    assign mem_addr = mem_we ? AW'(knot_index) : AW'(rd_idx);
    assign rx_s     = $signed(rx);
    assign ry_s     = $signed(ry);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign den      = {rx_s[31], rx_s} - {xlo_reg[31], xlo_reg};
    assign num      = {rx_s[31], rx_s} - {q_reg[31], q_reg};
    assign xmin     = asc_reg ? x0_reg : rx_s;
    assign xmax     = asc_reg ? rx_s : x0_reg;

    always_comb
    begin
        if (table_size_reg < 9'd2)
            n_eff = 9'd2;
        else if (int'(table_size_reg) > TABLE_DEPTH)
            n_eff = 9'(TABLE_DEPTH);
        else
            n_eff = table_size_reg;
    end

    tli_knot_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wx   (value_x),
        .wy   (value_y),
        .rx   (rx),
        .ry   (ry)
    );

    tli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        fin_next       = fin_reg;
        n_next         = n_reg;
        asc_next       = asc_reg;
        x0_next        = x0_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        reg_next       = reg_reg;
        xlo_next       = xlo_reg;
        ylo_next       = ylo_reg;
        yhi_next       = yhi_reg;
        diff_next      = diff_reg;
        w_next         = w_reg;
        pl_next        = pl_reg;
        ph_next        = ph_reg;
        psum_next      = psum_reg;
        res_y_next     = res_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_y_next     = out_y_reg;
        out_idx_next   = out_idx_reg;
        out_reg_next   = out_reg_reg;
        out_fin_next   = out_fin_reg;
        rd_idx         = 9'd0;
        div_req.start  = 1'b0;
        div_req.num    = num[32] ? -num : num;
        div_req.den    = den[32] ? -den : den;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && action == ACT_QUERY)
                begin
                    q_next     = $signed(value_x);
                    fin_next   = final_query;
                    n_next     = n_eff;
                    state_next = ST_X0;
                end
            end
            ST_X0:
            begin
                x0_next    = rx_s;
                rd_idx     = 9'd1;
                state_next = ST_X1;
            end
            ST_X1:
            begin
                asc_next   = rx_s > x0_reg;
                rd_idx     = n_reg - 9'd1;
                state_next = ST_XN;
            end
            ST_XN:
            begin
                if (q_reg <= xmin)
                begin
                    idx_next   = asc_reg ? 9'd0 : n_reg - 9'd1;
                    rd_idx     = asc_reg ? 9'd0 : n_reg - 9'd1;
                    reg_next   = REGION_LOW;
                    state_next = ST_YEND;
                end
                else if (q_reg >= xmax)
                begin
                    idx_next   = asc_reg ? n_reg - 9'd1 : 9'd0;
                    rd_idx     = asc_reg ? n_reg - 9'd1 : 9'd0;
                    reg_next   = REGION_HIGH;
                    state_next = ST_YEND;
                end
                else
                begin
                    lo_next    = 9'd0;
                    hi_next    = n_reg - 9'd1;
                    state_next = ST_SEARCH;
                end
            end
            ST_YEND:
            begin
                res_y_next = ry;
                state_next = ST_FIN;
            end
            ST_SEARCH:
            begin
                if (hi_reg - lo_reg > 9'd1)
                begin
                    mid_next   = mid_sum[9:1];
                    rd_idx     = mid_sum[9:1];
                    state_next = ST_CMP;
                end
                else
                begin
                    idx_next   = lo_reg;
                    rd_idx     = lo_reg;
                    state_next = ST_LO;
                end
            end
            ST_CMP:
            begin
                if ((q_reg >= rx_s) == asc_reg)
                    lo_next = mid_reg;
                else
                    hi_next = mid_reg;
                state_next = ST_SEARCH;
            end
            ST_LO:
            begin
                xlo_next   = rx_s;
                ylo_next   = ry_s;
                rd_idx     = lo_reg + 9'd1;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                if (den == 33'sd0)
                begin
                    res_y_next = ylo_reg;
                    reg_next   = REGION_ZERO;
                    state_next = ST_FIN;
                end
                else
                begin
                    yhi_next      = ry_s;
                    diff_next     = {ylo_reg[31], ylo_reg} - {ry_s[31], ry_s};
                    reg_next      = REGION_INSIDE;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    w_next     = div_rsp.weight;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                // low partial product on the bottom 17 bits of the difference
                pl_next    = w_reg * diff_reg[16:0];
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                ph_next    = 34'($signed({1'b0, w_reg}) * $signed(diff_reg[32:17]));
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                psum_next  = (48'($signed(ph_reg)) << 17) + {14'd0, pl_reg} + 48'd32768;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                res_y_next = yhi_reg + psum_reg[47:16];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_y_next     = res_y_reg;
                    out_idx_next   = idx_reg[7:0];
                    out_reg_next   = reg_reg;
                    out_fin_next   = fin_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            table_size_reg <= 9'd2;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                table_size_reg <= cfg_wdata;
            q_reg       <= q_next;
            fin_reg     <= fin_next;
            n_reg       <= n_next;
            asc_reg     <= asc_next;
            x0_reg      <= x0_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next;
            idx_reg     <= idx_next;
            reg_reg     <= reg_next;
            xlo_reg     <= xlo_next;
            ylo_reg     <= ylo_next;
            yhi_reg     <= yhi_next;
            diff_reg    <= diff_next;
            w_reg       <= w_next;
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            psum_reg    <= psum_next;
            res_y_reg   <= res_y_next;
            out_y_reg   <= out_y_next;
            out_idx_reg <= out_idx_next;
            out_reg_reg <= out_reg_next;
            out_fin_reg <= out_fin_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign interp_y       = out_y_reg;
    assign interval_index = out_idx_reg;
    assign region         = out_reg_reg;
    assign final_result   = out_fin_reg;

    a_cmp_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (hi_reg - lo_reg > 9'd1))
        else $error("search step without a wide interval");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg < hi_reg) && (hi_reg < n_reg))
        else $error("search bounds out of order");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("weight ready outside the divide wait");

    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (div_rsp.weight <= WEIGHT_ONE))
        else $error("weight above one");

endmodule

// ===== src/tli_knot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_knot_mem
// Knot store: x and y arrays on one shared address, registered read data.
// ----------------------------------------------------------------------------
module tli_knot_mem #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  logic [31:0]                    wx,
    input  logic [31:0]                    wy,
    output logic [31:0]                    rx,
    output logic [31:0]                    ry
);

    logic [31:0] x_mem [TABLE_DEPTH];
    logic [31:0] y_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            x_mem[addr] <= wx;
            y_mem[addr] <= wy;
        end
        rx <= x_mem[addr];
        ry <= y_mem[addr];
    end

endmodule

// ===== src/tli_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_div
// Restoring divider for the Q1.16 weight, one quotient bit per cycle,
// rounded half up and saturated at one.
// ----------------------------------------------------------------------------
module tli_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tli_pkg::div_req_t  req,
    output tli_pkg::div_rsp_t  rsp
);
    import tli_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [51:0]         rem_reg, rem_next;
    logic [51:0]         dsh_reg, dsh_next;
    logic [WEIGHT_W-1:0] quo_reg, quo_next;
    logic                ovf_reg, ovf_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        w_next    = w_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd17;
            // numerator scaled by 2^17 plus den, divisor 2*den: rounds half up
            rem_next  = ({19'd0, req.num} << 17) + {19'd0, req.den};
            dsh_next  = {19'd0, req.den} << 18;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_next = rem_reg - dsh_reg;
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == 5'd17)
                ovf_next = ge;
            else
                quo_next = {quo_reg[WEIGHT_W-2:0], ge};
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (ovf_reg || ({quo_reg[WEIGHT_W-2:0], ge} > WEIGHT_ONE))
                    w_next = WEIGHT_ONE;
                else
                    w_next = {quo_reg[WEIGHT_W-2:0], ge};
            end
            else
                cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_next;
            quo_reg  <= quo_next;
            ovf_reg  <= ovf_next;
            w_reg    <= w_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.weight = w_reg;

endmodule

// ===== bench/table_linear_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolator_tb
// Self-checking bench for the knot table interpolator. Tables of assorted
// sizes, both directions and flat or duplicate knots are loaded. Queries hit
// the clamped ends, exact knots and random points in between. Each result is
// checked against a local fixed-point model of the lookup and the blend.
// ----------------------------------------------------------------------------
module table_linear_interpolator_tb;
    import tli_pkg::*;

    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] y;
        logic [7:0]  idx;
        logic [1:0]  reg_code;
        logic        fin;
    } interp_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  knot_index;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic        final_query;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] interp_y;
    logic [7:0]  interval_index;
    logic [1:0]  region;
    logic        final_result;

    logic [31:0] knot_x [DEPTH];
    logic [31:0] knot_y [DEPTH];
    int unsigned size_in_use;
    interp_res_t expected_q [$];
    int          mismatches;
    int          results_seen;
    int          queries_sent;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    table_linear_interpolator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .knot_index(knot_index), .value_x(value_x), .value_y(value_y),
        .final_query(final_query), .out_valid(out_valid), .out_stall(out_stall),
        .interp_y(interp_y), .interval_index(interval_index), .region(region),
        .final_result(final_result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor(t / 65536) with plus-infinity ties handled by the caller's bias
    function automatic longint floor_q16(longint t);
        return t >>> 16;
    endfunction

    function automatic interp_res_t interpolate(logic signed [31:0] q, logic fin);
        interp_res_t r;
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic ascend;
        longint xmin;
        longint xmax;
        longint den;
        longint num;
        longint ud;
        longint un;
        longint w;
        longint yv;
        n = size_in_use;
        ascend = $signed(knot_x[1]) > $signed(knot_x[0]);
        xmin = ascend ? $signed(knot_x[0]) : $signed(knot_x[n-1]);
        xmax = ascend ? $signed(knot_x[n-1]) : $signed(knot_x[0]);
        r.fin = fin;
        if (q <= xmin)
        begin
            lo = ascend ? 0 : n - 1;
            yv = $signed(knot_y[lo]);
            r.reg_code = REGION_LOW;
        end
        else if (q >= xmax)
        begin
            lo = ascend ? n - 1 : 0;
            yv = $signed(knot_y[lo]);
            r.reg_code = REGION_HIGH;
        end
        else
        begin
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) >> 1;
                if ((q >= $signed(knot_x[mid])) == ascend)
                    lo = mid;
                else
                    hi = mid;
            end
            den = longint'($signed(knot_x[lo+1])) - $signed(knot_x[lo]);
            num = longint'($signed(knot_x[lo+1])) - q;
            if (den == 0)
            begin
                yv = $signed(knot_y[lo]);
                r.reg_code = REGION_ZERO;
            end
            else
            begin
                ud = den < 0 ? -den : den;
                un = num < 0 ? -num : num;
                w = ((un << 17) + ud) / (ud << 1);
                if (w > 65536)
                    w = 65536;
                yv = longint'($signed(knot_y[lo+1])) + floor_q16(w *
                     (longint'($signed(knot_y[lo])) - $signed(knot_y[lo+1])) + 32768);
                r.reg_code = REGION_INSIDE;
            end
        end
        r.y = yv[31:0];
        r.idx = lo[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR t=%0t %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        interp_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result y", interp_y, 32'h0);
            end
            else
            begin
                e = expected_q.pop_front();
                if (interp_y !== e.y)
                    report_mismatch("interp_y", interp_y, e.y);
                if (interval_index !== e.idx)
                    report_mismatch("interval_index", interval_index, e.idx);
                if (region !== e.reg_code)
                    report_mismatch("region", region, e.reg_code);
                if (final_result !== e.fin)
                    report_mismatch("final_result", final_result, e.fin);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall, drawn fresh at each falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Drop valid only while idling, so back-to-back requests keep it high
    task automatic send_request(logic act, logic [7:0] kidx, logic [31:0] x,
                                logic [31:0] y, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        knot_index  <= kidx;
        value_x     <= x;
        value_y     <= y;
        final_query <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (act == ACT_WRITE)
        begin
            knot_x[kidx] = x;
            knot_y[kidx] = y;
        end
        else
        begin
            expected_q.push_back(interpolate(x, fin));
            queries_sent++;
        end
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Write while idle; values outside 2..256 exercise the clamp in the block
    task automatic set_size(logic [8:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        size_in_use = v < 2 ? 2 : (v > DEPTH ? DEPTH : v);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // Load n knots, ascending or descending, with optional repeated x values
    task automatic load_table(int unsigned n, logic ascend, logic dup, logic wide);
        logic [31:0] xs [DEPTH];
        longint x;
        longint step;
        x = wide ? -64'sd2147483648 + $urandom_range(1000) : $signed($urandom_range(65536)) - 32768;
        step = wide ? (64'sd4294967000 / n) : 0;
        for (int i = 0; i < n; i++)
        begin
            xs[i] = x[31:0];
            if (wide)
                x = x + 1 + $urandom_range(step - 2);
            else
                x = x + ((dup && $urandom_range(3) == 0 && i != 0) ? 0 : 1 + $urandom_range(200000));
        end
        for (int i = 0; i < n; i++)
            send_request(ACT_WRITE, i[7:0], ascend ? xs[i] : xs[n-1-i], rand_word(),
                         1'($urandom_range(1)));
    endtask

    function automatic logic [31:0] pick_query();
        int unsigned k;
        k = $urandom_range(size_in_use - 1);
        case ($urandom_range(7))
            0: return knot_x[k];
            1: return knot_x[k] + 1;
            2: return knot_x[k] - 1;
            3: return $urandom;
            4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:
            begin
                if (k == size_in_use - 1)
                    k--;
                return 32'($signed(knot_x[k]) + longint'($urandom) %
                       (longint'($signed(knot_x[k+1])) - $signed(knot_x[k]) + 1));
            end
        endcase
    endfunction

    task automatic test_directed;
        set_size(9'd2);
        send_request(ACT_WRITE, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_request(ACT_WRITE, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_request(ACT_QUERY, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_QUERY, 8'h00, 32'h7FFF_FFFF, 32'h0, 1'b1);
        send_request(ACT_QUERY, 8'h00, 32'h0000_0000, 32'h0, 1'b0);
        send_request(ACT_QUERY, 8'h00, 32'h8000_0001, 32'h0, 1'b1);
        send_request(ACT_QUERY, 8'h00, 32'h7FFF_FFFE, 32'h0, 1'b0);
        // equal first knots read as descending
        send_request(ACT_WRITE, 8'd1, 32'h8000_0000, 32'h0001_0000, 1'b0);
        send_request(ACT_QUERY, 8'h00, 32'h0, 32'h0, 1'b1);
        send_request(ACT_QUERY, 8'h00, 32'h8000_0000, 32'h0, 1'b0);
        // descending pair, then size below and above range
        send_request(ACT_WRITE, 8'd0, 32'h0010_0000, 32'h0000_0003, 1'b0);
        send_request(ACT_WRITE, 8'd1, 32'hFFF0_0000, 32'hFFFF_FFFC, 1'b0);
        send_request(ACT_QUERY, 8'h00, 32'h0000_8000, 32'h0, 1'b1);
        send_request(ACT_QUERY, 8'h00, 32'hFFFF_8001, 32'h0, 1'b0);
        set_size(9'd0);
        send_request(ACT_QUERY, 8'h00, 32'h0000_0001, 32'h0, 1'b1);
        set_size(9'd1);
        send_request(ACT_QUERY, 8'h00, 32'h0008_0000, 32'h0, 1'b0);
        set_size(9'h1FF);
        load_table(256, 1'b1, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++)
            send_request(ACT_QUERY, 8'h00, pick_query(), $urandom, 1'($urandom_range(1)));
        // highest index written last, still within table
        send_request(ACT_WRITE, 8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_request(ACT_QUERY, 8'h00, 32'h7FFF_FFFE, 32'h0, 1'b1);
    endtask

    task automatic test_random(int unsigned queries);
        int unsigned n;
        int unsigned target;
        target = queries_sent + queries;
        while (queries_sent < target)
        begin
            n = $urandom_range(9) == 0 ? 256 : 2 + $urandom_range(14);
            set_size(n[8:0]);
            load_table(n, 1'($urandom_range(1)), $urandom_range(3) == 0,
                       $urandom_range(4) == 0);
            repeat (10 + $urandom_range(30))
                send_request(ACT_QUERY, 8'($urandom), pick_query(), $urandom,
                             1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        action = ACT_WRITE;
        knot_index = '0;
        value_x = '0;
        value_y = '0;
        final_query = 1'b0;
        out_stall = 1'b0;
        mismatches = 0;
        results_seen = 0;
        queries_sent = 0;
        cycles = 0;
        size_in_use = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 6;
        recv_idle_pct = 73;
        test_directed();
        test_random(120);
        send_idle_pct = 73;
        recv_idle_pct = 6;
        test_random(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(120);
        drain();

        $display("covered %0d queries, %0d results checked, table sizes 2..256",
                 queries_sent, results_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
